/* hdl/tgdd_pkg.sv */
// Shared types, constants and helper functions for the tone generator.
// Used by the controller, the datapath, the divider and the top level.
package tgdd_pkg;

  localparam int DIVIDEND_W = 27;
  localparam int DIVISOR_W  = 21;
  localparam int STEP_CNT_W = $clog2(DIVIDEND_W);

  localparam logic [31:0]           IDLE_COUNT  = 32'hFFFF_FFFF;
  localparam logic [23:0]           FREQ_LIMIT  = 24'd2000000;
  localparam logic [7:0]            VOLUME_MAX  = 8'd100;
  localparam logic [DIVIDEND_W-1:0] TIMER_CLOCK = DIVIDEND_W'(100000000);
  localparam logic signed [31:0]    MS_SCALE    = 32'sd1000;
  localparam logic [26:0]           PERIOD_RST  = 27'd100000;

  // The pulse is period*volume/200. The product is shifted right by 3 and
  // then divided by 25 as a multiplication by ceil(2^35/25) followed by a
  // shift by 35, which is exact for every product up to 100000000*100.
  localparam int          PULSE_PRE_SHIFT = 3;
  localparam int          PULSE_SHIFT     = 35;
  localparam logic [30:0] PULSE_RECIP     = 31'd1374389535;

  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_PLAY  = 3'd1;
  localparam logic [2:0] ACT_DEFER = 3'd2;
  localparam logic [2:0] ACT_START = 3'd3;
  localparam logic [2:0] ACT_STOP  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV1,
    S_DIV2,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic take_in;
    logic exec;
    logic div_start;
    logic period_wr;
    logic pulse_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_tone;
    logic div_done;
    logic pulse_ready;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [31:0] value;
    logic        expired;
  } cd_t;

  // One step of a countdown against the current period.
  function automatic cd_t count_step(input logic [31:0] c, input logic [26:0] p);
    cd_t r;
    r.value   = c;
    r.expired = 1'b0;
    priority if (c == IDLE_COUNT) begin
      r.value = c;
    end else if (c == 32'd0) begin
      r.value   = IDLE_COUNT;
      r.expired = 1'b1;
    end else if (c >= {5'd0, p}) begin
      r.value = c - {5'd0, p};
    end else begin
      r.value   = 32'd0;
      r.expired = 1'b1;
    end
    return r;
  endfunction

endpackage

/* hdl/tone_generator_with_delay_and_duration.sv */
// Top level of the buzzer tone controller; joins tgdd_ctrl and tgdd_datapath.
// Depends on tgdd_pkg.
//
// One command is taken at a time. Start, stop, unused codes, a deferred play
// with a nonzero delay, a play with a frequency of zero and a tick that starts
// no parked sound of nonzero frequency go through execute straight to the
// result transaction. A command that sets a new tone runs a one-bit-per-cycle
// divider for 27 steps on 100000000/freq to get the period, and the pulse
// period*volume/200 follows in two multiply stages, the division by 200 done
// as a shift and a reciprocal multiplication. A new command is accepted as
// soon as the result is in the output register, even while it waits to be taken.
module tone_generator_with_delay_and_duration
  import tgdd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // delay_count[31:0], tone_freq[55:32], tone_volume[63:56],
  // duration_ms[85:64], zero fill[87:86]
  input  logic [87:0] s_tdata,
  // action[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pwm_on[0], pwm_period[27:1], pwm_pulse[53:28], ticking[54], stop_event[55]
  output logic [55:0] m_tdata
);

  cmd_t cmd;
  sts_t sts;

  tgdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tgdd_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* hdl/tgdd_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tgdd_pkg for its widths.
module tgdd_div
  import tgdd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic                  done
);

  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(DIVIDEND_W - 1);

  logic                  active;
  logic [STEP_CNT_W-1:0] cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
      end else if (active && cnt == LAST_STEP) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt      <= '0;
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (active) begin
      cnt      <= cnt + 1'b1;
      rem      <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

/* hdl/tgdd_datapath.sv */
// Datapath: input latch, tone and countdown state, period divider, pulse
// multiplier and output register. Depends on tgdd_pkg and tgdd_div.
module tgdd_datapath
  import tgdd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [87:0] s_tdata,
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata
);

  // Latched transaction
  logic [2:0]         in_act;
  logic [31:0]        in_delay;
  logic [23:0]        in_freq;
  logic [7:0]         in_vol;
  logic signed [21:0] in_dur;

  // Block state
  logic [26:0]        period;
  logic [25:0]        pulse;
  logic [31:0]        origin_duration;
  logic [31:0]        duration_count;
  logic [31:0]        deferred_count;
  logic [23:0]        deferred_freq;
  logic [7:0]         deferred_volume;
  logic signed [21:0] deferred_duration;
  logic               output_enabled;
  logic               tick_enabled;
  logic               stop_flag;
  logic [6:0]           tone_vol;

  // Next values
  logic [31:0]        origin_duration_next;
  logic [31:0]        duration_count_next;
  logic [31:0]        deferred_count_next;
  logic [23:0]        deferred_freq_next;
  logic [7:0]         deferred_volume_next;
  logic signed [21:0] deferred_duration_next;
  logic               output_enabled_next;
  logic               tick_enabled_next;
  logic               stop_next;

  logic               do_play;
  logic               do_enable;
  logic               defer_fired;
  logic [23:0]        freq_sel;
  logic [7:0]         vol_sel;
  logic signed [21:0] dur_sel;
  logic signed [31:0] origin_new;
  logic [DIVISOR_W-1:0] freq_clamp;
  logic [6:0]           vol_clamp;
  cd_t                defer_cd;
  cd_t                dur_cd;

  logic [DIVIDEND_W-1:0] div_quo;
  logic                  div_done;
  logic [33:0]           pulse_prod;
  logic [60:0]           pulse_scaled;
  logic                  prod_valid;
  logic                  scaled_valid;

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      in_act   <= s_tuser;
      in_delay <= s_tdata[31:0];
      in_freq  <= s_tdata[55:32];
      in_vol   <= s_tdata[63:56];
      in_dur   <= s_tdata[85:64];
    end
  end

  assign defer_cd   = count_step(deferred_count, period);
  assign dur_cd     = count_step(duration_count, period);
  assign origin_new = 32'($signed({{10{dur_sel[21]}}, dur_sel}) * MS_SCALE);
  assign freq_clamp = (freq_sel > FREQ_LIMIT) ? FREQ_LIMIT[DIVISOR_W-1:0]
                                              : freq_sel[DIVISOR_W-1:0];
  assign vol_clamp  = (vol_sel > VOLUME_MAX) ? VOLUME_MAX[6:0] : vol_sel[6:0];

  always_comb begin
    origin_duration_next   = origin_duration;
    duration_count_next    = duration_count;
    deferred_count_next    = deferred_count;
    deferred_freq_next     = deferred_freq;
    deferred_volume_next   = deferred_volume;
    deferred_duration_next = deferred_duration;
    output_enabled_next    = output_enabled;
    tick_enabled_next      = tick_enabled;
    stop_next              = 1'b0;
    do_play                = 1'b0;
    do_enable              = 1'b0;
    defer_fired            = 1'b0;
    freq_sel               = in_freq;
    vol_sel                = in_vol;
    dur_sel                = in_dur;

    unique case (in_act)
      ACT_TICK: begin
        if (tick_enabled) begin
          if (defer_cd.expired) begin
            // The parked sound starts and the parking slots are emptied.
            defer_fired            = 1'b1;
            do_play                = 1'b1;
            do_enable              = 1'b1;
            freq_sel               = deferred_freq;
            vol_sel                = deferred_volume;
            dur_sel                = deferred_duration;
            deferred_count_next    = IDLE_COUNT;
            deferred_freq_next     = '0;
            deferred_volume_next   = '0;
            deferred_duration_next = '0;
          end else begin
            deferred_count_next = defer_cd.value;
            duration_count_next = dur_cd.value;
            if (dur_cd.expired) begin
              output_enabled_next = 1'b0;
              stop_next           = 1'b1;
              if (defer_cd.value == IDLE_COUNT) begin
                tick_enabled_next = 1'b0;
              end
            end
          end
        end
      end
      ACT_PLAY: begin
        do_play   = 1'b1;
        do_enable = 1'b1;
      end
      ACT_DEFER: begin
        if (in_delay == 32'd0) begin
          do_play   = 1'b1;
          do_enable = 1'b1;
        end else begin
          deferred_count_next    = in_delay;
          deferred_freq_next     = in_freq;
          deferred_volume_next   = in_vol;
          deferred_duration_next = in_dur;
          tick_enabled_next      = 1'b1;
        end
      end
      ACT_START: begin
        do_enable = 1'b1;
      end
      ACT_STOP: begin
        output_enabled_next = 1'b0;
      end
      default: begin
      end
    endcase

    if (do_play) begin
      origin_duration_next = origin_new;
    end
    if (do_enable) begin
      if (origin_duration_next != 32'd0 && !origin_duration_next[31]) begin
        duration_count_next = origin_duration_next;
        tick_enabled_next   = 1'b1;
      end
      output_enabled_next = 1'b1;
    end
    if (defer_fired && origin_duration_next == IDLE_COUNT) begin
      tick_enabled_next = 1'b0;
    end
  end

  assign sts.need_tone   = do_play && (freq_sel != 24'd0);
  assign sts.div_done    = div_done;
  assign sts.pulse_ready = scaled_valid;
  assign sts.out_free    = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      period            <= PERIOD_RST;
      pulse             <= '0;
      origin_duration   <= IDLE_COUNT;
      duration_count    <= IDLE_COUNT;
      deferred_count    <= IDLE_COUNT;
      deferred_freq     <= '0;
      deferred_volume   <= '0;
      deferred_duration <= '0;
      output_enabled    <= 1'b0;
      tick_enabled      <= 1'b0;
      prod_valid        <= 1'b0;
      scaled_valid      <= 1'b0;
      m_tvalid          <= 1'b0;
    end else begin
      if (cmd.exec) begin
        origin_duration   <= origin_duration_next;
        duration_count    <= duration_count_next;
        deferred_count    <= deferred_count_next;
        deferred_freq     <= deferred_freq_next;
        deferred_volume   <= deferred_volume_next;
        deferred_duration <= deferred_duration_next;
        output_enabled    <= output_enabled_next;
        tick_enabled      <= tick_enabled_next;
      end
      if (cmd.period_wr) begin
        period <= div_quo;
      end
      if (cmd.pulse_wr) begin
        pulse <= 26'(pulse_scaled >> PULSE_SHIFT);
      end
      prod_valid   <= cmd.period_wr;
      scaled_valid <= prod_valid;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      stop_flag <= stop_next;
      tone_vol  <= vol_clamp;
    end
    // The new period and the volume give the product, then the scaled
    // product in the cycle after.
    if (cmd.period_wr) begin
      pulse_prod <= {7'd0, div_quo} * {27'd0, tone_vol};
    end
    if (prod_valid) begin
      pulse_scaled <= 61'(pulse_prod >> PULSE_PRE_SHIFT) * 61'(PULSE_RECIP);
    end
    if (cmd.out_load) begin
      m_tdata <= {stop_flag, tick_enabled, pulse, period, output_enabled};
    end
  end

  // The divisor is taken in the execute cycle, straight from the clamp.
  tgdd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (TIMER_CLOCK),
    .divisor  (freq_clamp),
    .quotient (div_quo),
    .done     (div_done)
  );

endmodule

/* hdl/tgdd_ctrl.sv */
// Controller state machine: sequences accept, execute, the period division,
// the pulse multiply and the result transaction. Depends on tgdd_pkg.
module tgdd_ctrl
  import tgdd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_tvalid) state_next = S_EXEC;
      S_EXEC:   state_next = sts.need_tone ? S_DIV1 : S_RESULT;
      S_DIV1:   if (sts.div_done) state_next = S_DIV2;
      S_DIV2:   if (sts.pulse_ready) state_next = S_RESULT;
      S_RESULT: if (sts.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.take_in = s_tvalid;
      end
      S_EXEC: begin
        cmd.exec      = 1'b1;
        cmd.div_start = sts.need_tone;
      end
      S_DIV1: begin
        // Period is ready: store it, which also starts the pulse multiply.
        cmd.period_wr = sts.div_done;
      end
      S_DIV2: begin
        cmd.pulse_wr = sts.pulse_ready;
      end
      S_RESULT: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == S_DIV1 || state == S_DIV2))
    else $error("divider finished outside a division state");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("output register loaded while still occupied");
  a_tone_path: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && sts.need_tone) |=> state == S_DIV1)
    else $error("tone update did not enter the period division");
  a_div_latency: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !sts.div_done)
    else $error("divider finished right after start");
  a_pulse_in_div2: assert property (@(posedge clk) disable iff (rst)
    sts.pulse_ready |-> state == S_DIV2)
    else $error("pulse result ready outside the pulse state");
`endif

endmodule
